[rtl/core/swrm_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swrm_pkg
// Shared types and constants for the sliding window event rate meter.
// ----------------------------------------------------------------------------
package swrm_pkg;

    localparam int MAX_WINDOW_DEF = 16;
    localparam int TIME_W         = 48;
    localparam int RATE_W         = 32;
    localparam int WLEN_W         = 5;
    localparam int SCALE_W        = 28;

    localparam logic [WLEN_W-1:0]  WLEN_RESET  = 5'd16;
    localparam logic [SCALE_W-1:0] US_PER_S_Q8 = 28'd256000000;
    localparam logic [RATE_W-1:0]  RATE_MAX    = 32'hFFFF_FFFF;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SPAN = 4'b0010,
        S_DIV  = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

endpackage : swrm_pkg
`default_nettype wire

[rtl/core/swrm_ring.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swrm_ring
// Timestamp ring: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module swrm_ring #(
    parameter int DEPTH = 16,
    parameter int AW    = 4,
    parameter int DW    = 48
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [DW-1:0] i_wdata,
    input  wire logic          i_re,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule : swrm_ring
`default_nettype wire

[rtl/core/sliding_window_rate_meter_core.sv]
// A non-full window skips to S_DONE and a zero span skips the division; otherwise the result
//   comes from the restoring divider, which retires one quotient bit per cycle.
// A new event is not taken before the last one's result is registered; input is held off meanwhile.
// Output register decouples the sides: the next transfer is taken while a result waits.
// Reset (sync, active low): window length 16 (clamped to MAX_WINDOW), window empty.
// A window length write restarts the window; ring contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sliding_window_rate_meter_core
// Event rate over a ring of recent timestamps, Q24.8 events per second.
// ----------------------------------------------------------------------------
module sliding_window_rate_meter_core
    import swrm_pkg::*;
#(
    parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [WLEN_W-1:0] i_cfg_wdata,  // window_len
    input  wire logic              i_s_tvalid,
    output logic                   o_s_tready,
    input  wire logic [TIME_W-1:0] i_s_tdata,    // [47:0] event_time_us
    output logic                   o_m_tvalid,
    input  wire logic              i_m_tready,
    output logic      [RATE_W-1:0] o_m_tdata,    // [31:0] rate_q8
    output logic                   o_m_tuser     // [0] rate_valid
);

    localparam int      PTR_W   = $clog2(MAX_WINDOW);
    localparam int      WL_W    = $clog2(MAX_WINDOW + 1);
    localparam int      OFS_W   = PTR_W + 1;
    localparam longint  NUM_MAX = 64'(MAX_WINDOW - 1) * 64'(US_PER_S_Q8);
    localparam int      NUM_W   = $clog2(NUM_MAX + 1);
    localparam int      Q_W     = (NUM_W > RATE_W) ? NUM_W : RATE_W;
    localparam int      CNT_W   = $clog2(NUM_W);

    function automatic logic [WL_W-1:0] clamp_window(input logic [WLEN_W-1:0] v);
        int n;
        n = int'(v);
        if (n < 2) begin
            n = 2;
        end else if (n > MAX_WINDOW) begin
            n = MAX_WINDOW;
        end
        return WL_W'(n);
    endfunction

    t_state              r_state, n_state;
    logic [WL_W-1:0]     r_wl;
    logic [WL_W-1:0]     r_es, n_es;
    logic [PTR_W-1:0]    r_wp, n_wp;
    logic [TIME_W-1:0]   r_now;
    logic [TIME_W-1:0]   r_span;
    logic [TIME_W-1:0]   r_rem;
    logic [NUM_W-1:0]    r_num;
    logic [CNT_W-1:0]    r_cnt;
    logic                r_full;
    logic                r_zero;
    logic                r_m_valid;
    logic [RATE_W-1:0]   r_m_rate;
    logic                r_m_flag;

    logic                s_xfer;
    logic [TIME_W-1:0]   rd_data;
    logic [OFS_W-1:0]    ofs_diff;
    logic [PTR_W-1:0]    oldest;
    logic [TIME_W:0]     rem_sh;
    logic [TIME_W:0]     sub_a, sub_b, sub_d;
    logic                ge;
    logic [Q_W-1:0]      q_ext;
    logic [RATE_W-1:0]   rate;
    logic                out_free;

    assign o_s_tready = (r_state == S_IDLE);
    assign s_xfer     = i_s_tvalid && o_s_tready;
    assign out_free   = !r_m_valid || i_m_tready;

    assign n_wp = (r_wp == PTR_W'(MAX_WINDOW - 1)) ? '0 : r_wp + 1'b1;
    assign n_es = (r_es < r_wl) ? r_es + 1'b1 : r_es;

    // oldest = (newest - (window_len - 1)) mod MAX_WINDOW
    always_comb begin
        ofs_diff = OFS_W'(r_wp) - OFS_W'(r_wl - 1'b1);
        if (ofs_diff[OFS_W-1]) begin
            ofs_diff = ofs_diff + OFS_W'(MAX_WINDOW);
        end
        oldest = ofs_diff[PTR_W-1:0];
    end

    swrm_ring #(
        .DEPTH (MAX_WINDOW),
        .AW    (PTR_W),
        .DW    (TIME_W)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (s_xfer),
        .i_waddr (r_wp),
        .i_wdata (i_s_tdata),
        .i_re    (s_xfer),
        .i_raddr (oldest),
        .o_rdata (rd_data)
    );

    // Shared subtractor: span in S_SPAN, trial subtract in S_DIV
    assign rem_sh = {r_rem, r_num[NUM_W-1]};
    always_comb begin
        if (r_state == S_DIV) begin
            sub_a = rem_sh;
            sub_b = {1'b0, r_span};
        end else begin
            sub_a = {1'b0, r_now};
            sub_b = {1'b0, rd_data};
        end
        sub_d = sub_a - sub_b;
    end
    assign ge = !sub_d[TIME_W];

    assign q_ext = Q_W'(r_num);
    always_comb begin
        if (!r_full) begin
            rate = '0;
        end else if (r_zero || (|(q_ext >> RATE_W))) begin
            rate = RATE_MAX;
        end else begin
            rate = q_ext[RATE_W-1:0];
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (s_xfer) begin
                    n_state = (n_es >= r_wl) ? S_SPAN : S_DONE;
                end
            end
            S_SPAN: begin
                n_state = (sub_d[TIME_W-1:0] == '0) ? S_DONE : S_DIV;
            end
            S_DIV: begin
                if (r_cnt == '0) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_wl      <= clamp_window(WLEN_RESET);
            r_es      <= '0;
            r_wp      <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_wl <= clamp_window(i_cfg_wdata);
                r_es <= '0;
                r_wp <= '0;
            end else if (s_xfer) begin
                r_es <= n_es;
                r_wp <= n_wp;
            end
            if (r_state == S_DONE && out_free) begin
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (s_xfer) begin
                    r_now  <= i_s_tdata;
                    r_full <= (n_es >= r_wl);
                    r_zero <= 1'b0;
                    r_num  <= NUM_W'(64'(r_wl - 1'b1) * 64'(US_PER_S_Q8));
                end
            end
            S_SPAN: begin
                r_span <= sub_d[TIME_W-1:0];
                r_zero <= (sub_d[TIME_W-1:0] == '0);
                r_rem  <= '0;
                r_cnt  <= CNT_W'(NUM_W - 1);
            end
            S_DIV: begin
                r_rem <= ge ? sub_d[TIME_W-1:0] : rem_sh[TIME_W-1:0];
                r_num <= {r_num[NUM_W-2:0], ge};
                r_cnt <= r_cnt - 1'b1;
            end
            S_DONE: begin
                if (out_free) begin
                    r_m_rate <= rate;
                    r_m_flag <= r_full;
                end
            end
            default: ;
        endcase
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_rate;
    assign o_m_tuser  = r_m_flag;

`ifndef SYNTHESIS
    a_busy_after_xfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_xfer |=> !o_s_tready)
        else $error("input taken while previous transfer in progress");

    a_seen_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_es <= r_wl)
        else $error("event count exceeds window length");

    a_partial_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser) |-> (o_m_tdata == '0))
        else $error("nonzero rate for partial window");

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_span != '0 && r_full))
        else $error("divider running on zero span or partial window");
`endif

endmodule : sliding_window_rate_meter_core
`default_nettype wire

[verif/sliding_window_rate_meter_core_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_rate_meter_core_test
// Streams event timestamps into the rate meter under random back-pressure and
// checks every rate transfer against a timestamp ring model kept in the bench,
// across a range of window lengths written between runs.
// ----------------------------------------------------------------------------
module sliding_window_rate_meter_core_test;
    import swrm_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int DRAIN_CYCLES = 60;

    typedef struct packed {
        logic [RATE_W-1:0] rate_q8;
        logic              rate_valid;
    } t_rate_result;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_we = 1'b0;
    logic [WLEN_W-1:0] i_cfg_wdata = '0;
    logic              i_s_tvalid = 1'b0;
    logic              o_s_tready;
    logic [TIME_W-1:0] i_s_tdata = '0;   // [47:0] event_time_us
    logic              o_m_tvalid;
    logic              i_m_tready = 1'b0;
    logic [RATE_W-1:0] o_m_tdata;        // [31:0] rate_q8
    logic              o_m_tuser;        // [0] rate_valid

    // Window model
    logic [TIME_W-1:0] stamp_ring [MAX_WINDOW_DEF];
    logic [3:0]        ring_wr;
    logic [WLEN_W-1:0] fill_count;
    logic [WLEN_W-1:0] win_len;

    logic [TIME_W-1:0] stamp_queue [$];
    t_rate_result      rates_due [$];
    logic              in_taken = 1'b0;
    int                send_idle_pct = 0;
    int                take_idle_pct = 0;
    int                errors = 0;
    int                cycle_count = 0;

    sliding_window_rate_meter_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser)
    );

    always #4 i_clk = ~i_clk;

    function automatic void set_window(input logic [WLEN_W-1:0] v);
        if (v < 2) begin
            win_len = WLEN_W'(2);
        end else if (v > MAX_WINDOW_DEF) begin
            win_len = WLEN_W'(MAX_WINDOW_DEF);
        end else begin
            win_len = v;
        end
        ring_wr = '0;
        fill_count = '0;
    endfunction

    function automatic void meter_event(input logic [TIME_W-1:0] t,
                                        output logic [RATE_W-1:0] rate,
                                        output logic ok);
        logic [3:0]        oldest;
        logic [TIME_W-1:0] span;
        logic [63:0]       num;
        logic [63:0]       quo;
        stamp_ring[ring_wr] = t;
        oldest = ring_wr - 4'(win_len - WLEN_W'(1));
        ring_wr = ring_wr + 4'd1;
        if (fill_count < win_len) fill_count = fill_count + WLEN_W'(1);
        rate = '0;
        ok = 1'b0;
        if (fill_count == win_len) begin
            span = t - stamp_ring[oldest];
            num = (64'(win_len) - 64'd1) * 64'(US_PER_S_Q8);
            if (span == '0) begin
                rate = RATE_MAX;
            end else begin
                quo = num / 64'(span);
                rate = (quo > 64'(RATE_MAX)) ? RATE_MAX : quo[RATE_W-1:0];
            end
            ok = 1'b1;
        end
    endfunction

    // Input driver
    always @(negedge i_clk) begin : drive_events
        logic              nxt_valid;
        logic [TIME_W-1:0] nxt_data;
        nxt_valid = i_s_tvalid;
        nxt_data = i_s_tdata;
        if (i_rst_n && (!i_s_tvalid || in_taken)) begin
            nxt_valid = 1'b0;
            if (stamp_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                nxt_valid = 1'b1;
                nxt_data = stamp_queue[0];
                stamp_queue.delete(0);
            end
        end
        i_s_tvalid <= nxt_valid;
        i_s_tdata <= nxt_data;
    end

    always @(negedge i_clk) begin
        i_m_tready <= i_rst_n && ($urandom_range(99) >= take_idle_pct);
    end

    // Monitor and checker
    always @(posedge i_clk) begin : watch_rates
        t_rate_result want;
        in_taken <= i_rst_n && i_s_tvalid && o_s_tready;
        if (i_rst_n && i_s_tvalid && o_s_tready) begin
            meter_event(i_s_tdata, want.rate_q8, want.rate_valid);
            rates_due = {rates_due, want};
        end
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (rates_due.size() == 0) begin
                $display("%0t: unexpected rate transfer, expected none, actual rate_q8=%h valid=%b",
                         $time, o_m_tdata, o_m_tuser);
                errors++;
            end else begin
                want = rates_due[0];
                rates_due.delete(0);
                if (o_m_tdata !== want.rate_q8) begin
                    $display("%0t: rate_q8 mismatch, expected %h, actual %h",
                             $time, want.rate_q8, o_m_tdata);
                    errors++;
                end
                if (o_m_tuser !== want.rate_valid) begin
                    $display("%0t: rate_valid mismatch, expected %b, actual %b",
                             $time, want.rate_valid, o_m_tuser);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("** sliding_window_rate_meter_core: FAILED **");
            $finish;
        end
    end

    task automatic wait_drained();
        while (stamp_queue.size() != 0 || i_s_tvalid || rates_due.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic write_window(input logic [WLEN_W-1:0] v);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        set_window(v);
    endtask

    // Mostly steady event streams; some repeats, long gaps and backward steps.
    task automatic queue_event_run(input int count);
        logic [TIME_W-1:0] stamp;
        logic [TIME_W-1:0] step;
        int                left;
        int                pick;
        stamp = TIME_W'({$urandom, $urandom});
        if ($urandom_range(3) == 0) stamp = '1 - TIME_W'($urandom_range(5000));
        left = count;
        @(posedge i_clk);
        while (left > 0) begin
            pick = $urandom_range(99);
            if (pick < 8) begin
                // identical stamps across a whole window: zero span
                repeat (win_len) stamp_queue = {stamp_queue, stamp};
                left -= win_len;
            end else begin
                if (pick < 60) begin
                    step = TIME_W'($urandom_range(2000, 1));
                end else if (pick < 70) begin
                    step = '0;
                end else if (pick < 85) begin
                    step = TIME_W'($urandom_range(1 << 24, 1));
                end else if (pick < 93) begin
                    step = TIME_W'({$urandom, $urandom});
                end else begin
                    step = -TIME_W'($urandom_range(3000, 1));
                end
                stamp = stamp + step;
                stamp_queue = {stamp_queue, stamp};
                left--;
            end
        end
    endtask

    initial begin
        logic [WLEN_W-1:0] wlen_val;
        set_window(WLEN_RESET);
        send_idle_pct = 37;
        take_idle_pct = 72;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset window of 16, stamps wrapping through zero
        @(posedge i_clk);
        for (int k = 0; k < 16; k++) begin
            stamp_queue = {stamp_queue, 48'hFFFF_FFFF_FFF8 + TIME_W'(k)};
        end
        wait_drained();

        // Length below range, zero span, tiny rate, span across the wrap
        write_window(WLEN_W'(0));
        @(posedge i_clk);
        stamp_queue = {stamp_queue, 48'd5};
        stamp_queue = {stamp_queue, 48'd5};
        stamp_queue = {stamp_queue, 48'd6};
        stamp_queue = {stamp_queue, 48'hFFFF_FFFF_FFFF};
        stamp_queue = {stamp_queue, 48'h0};
        wait_drained();

        write_window(WLEN_W'(1));
        @(posedge i_clk);
        stamp_queue = {stamp_queue, 48'h0};
        stamp_queue = {stamp_queue, 48'h8000_0000_0000};
        wait_drained();

        for (int seg = 0; seg < 12; seg++) begin
            if (seg == 4) begin
                send_idle_pct = 72;
                take_idle_pct = 37;
            end else if (seg == 8) begin
                send_idle_pct = 0;
                take_idle_pct = 0;
            end
            case (seg)
                0: wlen_val = WLEN_W'(31);
                1: wlen_val = WLEN_W'(2);
                2: wlen_val = WLEN_W'(17);
                3: wlen_val = WLEN_W'(9);
                4: wlen_val = WLEN_W'(3);
                5: wlen_val = WLEN_W'(16);
                6: wlen_val = WLEN_W'(0);
                9: wlen_val = WLEN_W'(15);
                11: wlen_val = WLEN_W'(1);
                default: wlen_val = WLEN_W'($urandom_range(31));
            endcase
            write_window(wlen_val);
            queue_event_run($urandom_range(75, 40));
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("** sliding_window_rate_meter_core: PASSED **");
        end else begin
            $display("** sliding_window_rate_meter_core: FAILED **");
        end
        $finish;
    end

endmodule

[sliding_window_rate_meter_core.f]
rtl/core/swrm_pkg.sv
rtl/core/swrm_ring.sv
rtl/core/sliding_window_rate_meter_core.sv
verif/sliding_window_rate_meter_core_test.sv
